// ===== hw/rtl/text_console_cursor_scroll_unit_assert.svh =====
// Assertion macros for the text console cursor/scroll unit.
// Expect signals clk and rst_n in the scope of use; empty when SYNTH is defined.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TCCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCCS_ASSERT_IMP(lbl, ante, cons, msg)
`define TCCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tccs_pkg.sv =====
// Shared types, constants and helpers of the text console cursor/scroll unit.
// No dependencies.
`default_nettype none

package tccs_pkg;

  localparam int unsigned MAX_COLS   = 128;
  localparam int unsigned MAX_ROWS   = 32;
  localparam int unsigned TAB_WIDTH  = 4;
  localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  // item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // control characters
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // register indexes
  localparam logic [1:0] CFG_ATTR = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_ROWS = 2'd2;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] cols;   // effective, 1..MAX_COLS
    logic [5:0] rows;   // effective, 1..MAX_ROWS
  } tccs_cfg_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } tccs_res_t;

  function automatic logic [7:0] eff_cols(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) r = 8'd1;
    else if (v > 8'(MAX_COLS)) r = 8'(MAX_COLS);
    return r;
  endfunction

  function automatic logic [5:0] eff_rows(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (v > 6'(MAX_ROWS)) r = 6'(MAX_ROWS);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tccs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tccs_ctrl.sv =====
// Sequencer of the console unit: cursor, item execution, row scroll and clear walks.
// Owns the cell RAM (tccs_ram); uses tccs_pkg.
`default_nettype none

module tccs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_take,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          char_code,
  input  wire logic [6:0]          read_col,
  input  wire logic [4:0]          read_row,
  input  wire tccs_pkg::tccs_cfg_t cfg,
  input  wire logic                out_free,
  output logic                     item_ready,
  output logic                     res_valid,
  output tccs_pkg::tccs_res_t      res
);

  localparam int unsigned AW = tccs_pkg::ADDR_W;
  localparam int unsigned CW = tccs_pkg::ADDR_W + 1;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_RDATA = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]  kind_r;
  logic [7:0]  char_r;
  logic [6:0]  rcol_r;
  logic [4:0]  rrow_r;

  logic [6:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic        scroll_r, scroll_nxt;
  logic        wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic        wz_r, wz_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  tccs_pkg::tccs_res_t res_r, res_r_nxt;

  logic [6:0]  col_s;
  logic [4:0]  row_s;
  logic [5:0]  mul_a;
  logic [13:0] prod_full;
  logic [AW-1:0] addr_sum;
  logic        rd_in;
  logic [7:0]  col_inc;
  logic [7:0]  tab_t;
  logic        row_last;
  logic [4:0]  adv_row;
  logic [CW-1:0] end_w;
  logic [CW-1:0] p_inc;
  logic        need_scroll;
  logic        done;
  logic        scr;
  logic [15:0] rd_cell;
  tccs_pkg::tccs_res_t res_now;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [15:0] ram_wdata;
  logic [15:0] ram_rdata;

  function automatic logic [6:0] tab_wrap(input logic [7:0] t, input logic [7:0] c);
    logic [7:0] v;
    v = t;
    for (int i = 0; i < tccs_pkg::TAB_WIDTH; i++) begin
      if (v >= c) v = v - c;
    end
    return v[6:0];
  endfunction

  tccs_ram #(
    .WIDTH(tccs_pkg::CELL_W),
    .DEPTH(tccs_pkg::CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // cursor kept inside the active area even after the area shrinks
  assign col_s = ({1'b0, col_r} >= cfg.cols) ? 7'(cfg.cols - 8'd1) : col_r;
  assign row_s = ({1'b0, row_r} >= cfg.rows) ? 5'(cfg.rows - 6'd1) : row_r;

  always_comb begin
    priority if (kind_r == tccs_pkg::KIND_READ) mul_a = {1'b0, rrow_r};
    else if (kind_r == tccs_pkg::KIND_CLEAR)   mul_a = cfg.rows;
    else                                       mul_a = {1'b0, row_s};
  end

  assign prod_full = 14'(mul_a) * 14'(cfg.cols);
  assign addr_sum  = prod_full[AW-1:0] +
                     AW'((kind_r == tccs_pkg::KIND_READ) ? rcol_r : col_s);
  assign rd_in     = ({1'b0, rcol_r} < cfg.cols) && ({1'b0, rrow_r} < cfg.rows);
  assign col_inc   = {1'b0, col_s} + 8'd1;
  assign tab_t     = 8'(({1'b0, col_s} / tccs_pkg::TAB_WIDTH + 1) * tccs_pkg::TAB_WIDTH);
  assign row_last  = ({1'b0, row_s} + 6'd1) >= cfg.rows;
  assign adv_row   = row_last ? row_s : row_s + 5'd1;
  // scroll walks one extra row to blank the bottom line
  assign end_w     = lim_r + (scroll_r ? CW'(cfg.cols) : CW'(0));
  assign p_inc     = {1'b0, p_r} + CW'(1);

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_s;
    row_nxt     = row_s;
    p_nxt       = p_r;
    lim_nxt     = lim_r;
    scroll_nxt  = scroll_r;
    wv_nxt      = 1'b0;
    wa_nxt      = p_r;
    wz_nxt      = 1'b1;
    rd_ok_nxt   = rd_ok_r;
    res_r_nxt   = res_r;
    need_scroll = 1'b0;
    done        = 1'b0;
    scr         = 1'b0;
    rd_cell     = '0;
    ram_we      = 1'b0;
    ram_waddr   = addr_sum;
    ram_wdata   = {cfg.attr, char_r};
    ram_raddr   = addr_sum;

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = '0;
        p_nxt     = p_inc[AW-1:0];
        if (p_inc == CW'(tccs_pkg::CELL_COUNT)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (item_take) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (kind_r)
          tccs_pkg::KIND_PUT: begin
            if (char_r == tccs_pkg::CH_LF || char_r == tccs_pkg::CH_CR) begin
              col_nxt     = '0;
              row_nxt     = adv_row;
              need_scroll = row_last;
            end else if (char_r == tccs_pkg::CH_TAB) begin
              if (tab_t >= cfg.cols) begin
                col_nxt     = tab_wrap(tab_t, cfg.cols);
                row_nxt     = adv_row;
                need_scroll = row_last;
              end else begin
                col_nxt = tab_t[6:0];
              end
            end else begin
              ram_we = 1'b1;
              if (col_inc >= cfg.cols) begin
                col_nxt     = '0;
                row_nxt     = adv_row;
                need_scroll = row_last;
              end else begin
                col_nxt = col_inc[6:0];
              end
            end
            if (need_scroll) begin
              lim_nxt    = prod_full[CW-1:0];   // columns * (rows - 1)
              scroll_nxt = 1'b1;
              p_nxt      = '0;
              state_nxt  = S_WALK;
            end else begin
              done = 1'b1;
            end
          end
          tccs_pkg::KIND_CLEAR: begin
            col_nxt    = '0;
            row_nxt    = '0;
            lim_nxt    = prod_full[CW-1:0];     // columns * rows
            scroll_nxt = 1'b0;
            p_nxt      = '0;
            state_nxt  = S_WALK;
          end
          tccs_pkg::KIND_READ: begin
            rd_ok_nxt = rd_in;
            state_nxt = S_RDATA;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_RDATA: begin
        done    = 1'b1;
        rd_cell = rd_ok_r ? ram_rdata : '0;
      end
      S_WALK: begin
        // read one row ahead, write the delayed beat of the previous cycle
        ram_raddr = p_r + AW'(cfg.cols);
        wv_nxt    = 1'b1;
        wa_nxt    = p_r;
        wz_nxt    = !scroll_r || ({1'b0, p_r} >= lim_r);
        ram_we    = wv_r;
        ram_waddr = wa_r;
        ram_wdata = wz_r ? '0 : ram_rdata;
        p_nxt     = p_inc[AW-1:0];
        if (p_inc == end_w) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        ram_we    = wv_r;
        ram_waddr = wa_r;
        ram_wdata = wz_r ? '0 : ram_rdata;
        done      = 1'b1;
        scr       = scroll_r;
      end
      S_HOLD: begin
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_now = '{cursor_col: col_nxt, cursor_row: row_nxt,
                cell_char: rd_cell[7:0], cell_attr: rd_cell[15:8], scrolled: scr};

    if (state_r == S_HOLD) begin
      res_valid = out_free;
      res       = res_r;
      if (out_free) state_nxt = S_IDLE;
    end else begin
      res_valid = done && out_free;
      res       = res_now;
      if (done) begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
          res_r_nxt = res_now;
        end
      end
    end
  end

  assign item_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      p_r     <= '0;
      col_r   <= '0;
      row_r   <= '0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wv_r    <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_ready) begin
      kind_r <= kind;
      char_r <= char_code;
      rcol_r <= read_col;
      rrow_r <= read_row;
    end
    lim_r    <= lim_nxt;
    scroll_r <= scroll_nxt;
    wa_r     <= wa_nxt;
    wz_r     <= wz_nxt;
    rd_ok_r  <= rd_ok_nxt;
    res_r    <= res_r_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cursor_scroll_unit.sv =====
// Text console engine: a 4096-cell character/attribute RAM and a cursor. Put writes
// the byte with the attribute register at the cursor and advances (LF/CR go to the
// start of the next row, TAB to the next multiple of 4); running off the last row
// scrolls the active area up one row and blanks the bottom row. Clear blanks the
// active area and homes the cursor; read returns one cell. Every item gives one
// result beat. A put or control character that does not scroll is done in S_EXEC, a read
// in S_RDATA once the registered RAM read data arrives; a scroll or clear walks the
// cell RAM through its single write port one cell per cycle and finishes in S_FLUSH.
// The input is taken again once the result beat is registered; a stalled output holds
// the result in S_HOLD and keeps the next item out. After reset the RAM is cleared in
// one pass over all 4096 cells during which in_stall stays high; configuration writes
// are taken at any time (cfg_ready is always high) and must only be issued while no
// item is in flight.
// Depends on tccs_pkg, tccs_ctrl, tccs_ram and the assertion macro header.
`default_nettype none

`include "text_console_cursor_scroll_unit_assert.svh"

module text_console_cursor_scroll_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_char_code,
  input  wire logic [6:0] in_read_col,
  input  wire logic [4:0] in_read_row,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_cursor_col,
  output logic [4:0]      out_cursor_row,
  output logic [7:0]      out_cell_char,
  output logic [7:0]      out_cell_attr,
  output logic            out_scrolled,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] attr_r, attr_nxt;
  logic [7:0] cols_r, cols_nxt;
  logic [5:0] rows_r, rows_nxt;
  tccs_pkg::tccs_cfg_t cfg;

  logic item_ready;
  logic item_take;
  logic out_free;
  logic res_valid;
  tccs_pkg::tccs_res_t res;

  logic out_valid_r, out_valid_nxt;
  tccs_pkg::tccs_res_t out_res_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    attr_nxt = attr_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tccs_pkg::CFG_ATTR: attr_nxt = cfg_data;
        tccs_pkg::CFG_COLS: cols_nxt = tccs_pkg::eff_cols(cfg_data);
        tccs_pkg::CFG_ROWS: rows_nxt = tccs_pkg::eff_rows(cfg_data[5:0]);
        default: ;
      endcase
    end
  end

  assign cfg = '{attr: attr_r, cols: cols_r, rows: rows_r};

  assign in_stall  = !item_ready;
  assign item_take = in_valid && item_ready;
  // output register takes a new beat when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (item_take),
    .kind      (in_kind),
    .char_code (in_char_code),
    .read_col  (in_read_col),
    .read_row  (in_read_row),
    .cfg       (cfg),
    .out_free  (out_free),
    .item_ready(item_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= 8'd0;
      cols_r      <= 8'd80;
      rows_r      <= 6'd25;
      out_valid_r <= 1'b0;
    end else begin
      attr_r      <= attr_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_res_r.cursor_col;
  assign out_cursor_row = out_res_r.cursor_row;
  assign out_cell_char  = out_res_r.cell_char;
  assign out_cell_attr  = out_res_r.cell_attr;
  assign out_scrolled   = out_res_r.scrolled;

  `TCCS_ASSERT_IMP(a_no_beat_overwrite, res_valid, !out_valid_r || !out_stall, "result beat would overwrite a waiting beat")
  `TCCS_ASSERT_IMP(a_cursor_in_area, res_valid, (8'(res.cursor_col) < cols_r) && (6'(res.cursor_row) < rows_r), "cursor outside active area")
  `TCCS_ASSERT_NXT(a_one_item_at_a_time, in_valid && !in_stall, in_stall, "input taken while an item is in progress")

endmodule

`default_nettype wire
